[rtl/irv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irv_pkg: shared types and constants for the instant-runoff tally
// Sizes of the ballot store, candidate field widths and the sequencer states.
// ----------------------------------------------------------------------------
package irv_pkg;

	localparam int MaxCandidates = 16;
	localparam int MaxBallots    = 4096;
	localparam int CandW         = 4;
	localparam int BallotW       = MaxCandidates * CandW;
	localparam int AddrW         = $clog2(MaxBallots);
	localparam int TotalW        = AddrW + 1;
	localparam int LenW          = $clog2(MaxCandidates + 1);
	localparam int PrefW         = 5;
	localparam int CfgW          = 5;
	localparam int StoreW        = BallotW + LenW;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_SCAN,
		ST_PICK,
		ST_FIND,
		ST_DONE
	} irv_state_t;

endpackage

[rtl/irv_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irv_ram: generic single-port RAM
// One address per cycle, read every cycle and written when we is high; read data is registered.
// ----------------------------------------------------------------------------
module irv_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

[rtl/instant_runoff_tally.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instant_runoff_tally: ranked-ballot instant-runoff counter
// Loads ballots one preference per request, then runs elimination rounds.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one preference per request: tdata = preference (5 bits),
//   tuser = ballot_end, tlast = election_end. s_axis_tready stays high
//   during loading. After an election_end request the block drops tready
//   and counts. Each round reads every stored ballot once from the ballot
//   RAM (one read per ballot, then one rank examined per cycle until the
//   first live rank is found or the ranks run out), closes the pass, then
//   walks the tallies one per cycle to pick the candidate to eliminate.
//   The time to the result is set by the single RAM port and the shared
//   rank/tally compare unit. The result (winner, ballots_stored,
//   ballot_overflow) waits in an output register on m_axis; the next
//   election's loading starts only once it has been taken, so a stalled
//   receiver holds the block. Reset clears the counters, flags and
//   candidate register (to 16); the ballot RAM is not cleared since only
//   entries below the fill count are read. cfg_we writes candidates_in_use;
//   the user must write it only while the block is idle, as the block
//   does not enforce this.
// ----------------------------------------------------------------------------
module instant_runoff_tally (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [irv_pkg::CfgW-1:0] cfg_wdata,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [7:0]              s_axis_tdata,  // [4:0] preference
	input  logic                    s_axis_tuser,  // ballot_end
	input  logic                    s_axis_tlast,  // election_end
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [23:0]             m_axis_tdata   // [4:0] winner, [17:5] ballots_stored,
	                                               // [18] ballot_overflow
);
	import irv_pkg::*;

	irv_state_t state_q, state_d;

	logic [CfgW-1:0]   cand_cfg_q;
	logic [4:0]        cnt_c;           // clamped candidate count 1..16
	logic [BallotW-1:0] asm_q;
	logic [LenW-1:0]   pos_q;
	logic [TotalW-1:0] total_q;
	logic              ovf_q;
	logic [MaxCandidates-1:0] elim_q;
	logic [TotalW-1:0] tally_q [MaxCandidates];
	logic [TotalW-1:0] bidx_q;
	logic [LenW-1:0]   rank_q;
	logic [4:0]        left_q;
	logic [4:0]        k_q;
	logic [3:0]        low_q;
	logic [TotalW-1:0] lowest_q;
	logic              found_q;
	logic [BallotW-1:0] cur_q;
	logic [LenW-1:0]   curlen_q;
	logic              ovalid_q;
	logic [4:0]        win_q;
	logic [TotalW-1:0] ores_total_q;
	logic              ores_ovf_q;
	logic              first_scan_q;

	logic [AddrW-1:0]  ram_addr;
	logic              ram_we;
	logic [StoreW-1:0] ram_wdata, ram_rdata;

	logic acc, pref_ok, bend, eend, do_close, do_store;
	logic [PrefW-1:0] pref;
	logic [BallotW-1:0] asm_new;
	logic [LenW-1:0] pos_new;
	logic [3:0] cand_c;
	logic cand_live;
	logic [BallotW-1:0] scan_bal;
	logic [LenW-1:0]    scan_len, rd_len;

	assign cnt_c = (cand_cfg_q == '0) ? 5'd1 :
		(cand_cfg_q > 5'(MaxCandidates)) ? 5'(MaxCandidates) : cand_cfg_q;

	assign s_axis_tready = (state_q == ST_LOAD) && !ovalid_q;
	assign acc  = s_axis_tvalid && s_axis_tready;
	assign pref = s_axis_tdata[PrefW-1:0];
	assign bend = s_axis_tuser;
	assign eend = s_axis_tlast;
	assign pref_ok = (pref >= 5'd1) && (pref <= cnt_c) && (pos_q < LenW'(MaxCandidates));

	always_comb begin
		asm_new = asm_q;
		pos_new = pos_q;
		if (pref_ok) begin
			asm_new = asm_q | (BallotW'(pref - 5'd1) << (CandW * pos_q));
			pos_new = pos_q + 1'b1;
		end
	end

	assign do_close = acc && (bend || (eend && pos_new != '0));
	assign do_store = do_close && (total_q < TotalW'(MaxBallots));

	// shared compare unit: current rank of the ballot under scan; on the first
	// scan cycle the ballot comes straight from the RAM output, later from cur_q
	assign rd_len   = (ram_rdata[StoreW-1:BallotW] > LenW'(MaxCandidates)) ?
		LenW'(MaxCandidates) : ram_rdata[StoreW-1:BallotW];
	assign scan_bal = first_scan_q ? ram_rdata[BallotW-1:0] : cur_q;
	assign scan_len = first_scan_q ? rd_len : curlen_q;
	assign cand_c    = scan_bal[CandW*rank_q[3:0] +: CandW];
	assign cand_live = ({1'b0, cand_c} < cnt_c) && !elim_q[cand_c];

	assign ram_we    = do_store;
	assign ram_wdata = {pos_new, asm_new};
	assign ram_addr  = do_store ? total_q[AddrW-1:0] : bidx_q[AddrW-1:0];

	irv_ram #(.Width(StoreW), .Depth(MaxBallots)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: if (acc && eend) state_d = (cnt_c > 5'd1) ? ST_READ : ST_FIND;
			ST_READ: state_d = (bidx_q < total_q) ? ST_SCAN : ST_PICK;
			ST_SCAN: begin
				if (rank_q >= scan_len || cand_live) state_d = ST_READ;
			end
			ST_PICK: begin
				if (k_q == cnt_c - 5'd1) state_d = (left_q == 5'd2) ? ST_FIND : ST_READ;
			end
			ST_FIND: if (k_q == cnt_c - 5'd1 || !elim_q[k_q[3:0]]) state_d = ST_DONE;
			ST_DONE: state_d = ST_LOAD;
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			cand_cfg_q   <= 5'd16;
			asm_q        <= '0;
			pos_q        <= '0;
			total_q      <= '0;
			ovf_q        <= 1'b0;
			elim_q       <= '0;
			bidx_q       <= '0;
			rank_q       <= '0;
			left_q       <= '0;
			k_q          <= '0;
			low_q        <= '0;
			lowest_q     <= '0;
			found_q      <= 1'b0;
			ovalid_q     <= 1'b0;
			win_q        <= 5'd1;
			ores_total_q <= '0;
			ores_ovf_q   <= 1'b0;
			for (int i = 0; i < MaxCandidates; i++) tally_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cand_cfg_q <= cfg_wdata;
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (acc) begin
						asm_q <= asm_new;
						pos_q <= pos_new;
						if (do_close) begin
							asm_q <= '0;
							pos_q <= '0;
							if (do_store) total_q <= total_q + 1'b1;
							else ovf_q <= 1'b1;
						end
						if (eend) begin
							// start the first round
							elim_q <= '0;
							bidx_q <= '0;
							k_q    <= '0;
							left_q <= cnt_c;
							found_q <= 1'b0;
							for (int i = 0; i < MaxCandidates; i++) tally_q[i] <= '0;
						end
					end
				end
				ST_READ: begin
					// RAM data for bidx_q arrives next cycle
					rank_q <= '0;
					bidx_q <= bidx_q + 1'b1;
					found_q <= 1'b0;
					k_q <= '0;
				end
				ST_SCAN: begin
					if (rank_q < scan_len) begin
						if (cand_live) tally_q[cand_c] <= tally_q[cand_c] + 1'b1;
						else rank_q <= rank_q + 1'b1;
					end
				end
				ST_PICK: begin
					if (!elim_q[k_q[3:0]] && (!found_q || tally_q[k_q[3:0]] < lowest_q)) begin
						found_q  <= 1'b1;
						lowest_q <= tally_q[k_q[3:0]];
						low_q    <= k_q[3:0];
					end
					k_q <= k_q + 1'b1;
					if (k_q == cnt_c - 5'd1) begin
						// eliminate, advance round
						if (!elim_q[k_q[3:0]] && (!found_q || tally_q[k_q[3:0]] < lowest_q))
							elim_q[k_q[3:0]] <= 1'b1;
						else
							elim_q[low_q] <= 1'b1;
						left_q <= left_q - 1'b1;
						bidx_q <= '0;
						k_q    <= '0;
						for (int i = 0; i < MaxCandidates; i++) tally_q[i] <= '0;
					end
				end
				ST_FIND: begin
					if (state_d == ST_DONE) begin
						win_q        <= elim_q[k_q[3:0]] ? 5'd1 : k_q + 5'd1;
						ores_total_q <= total_q;
						ores_ovf_q   <= ovf_q;
					end
					k_q <= k_q + 1'b1;
				end
				ST_DONE: begin
					ovalid_q <= 1'b1;
					total_q  <= '0;
					ovf_q    <= 1'b0;
					elim_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// hold the ballot read from RAM for the rest of its scan
	always_ff @(posedge clk) begin
		if (first_scan_q) begin
			cur_q    <= scan_bal;
			curlen_q <= scan_len;
		end
	end

	// marks the scan cycle in which the RAM output carries the new ballot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_scan_q <= 1'b0;
		else first_scan_q <= (state_q == ST_READ) && (bidx_q < total_q);
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {5'd0, ores_ovf_q, ores_total_q, win_q};

endmodule

[rtl/irv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irv_checker: port-level checks for the instant-runoff tally
// Watches the streaming ports only.
// ----------------------------------------------------------------------------
module irv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("ready after election end");
	a_nordy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("loading while result pending");
	a_win: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[4:0] <= 5'd16)
		else $error("winner out of range");
endmodule

bind instant_runoff_tally irv_checker u_irv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

[tb/sv/irv_tally_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irv_tally_checker: result predictor and scoreboard for the runoff tally
// Watches the config, request and result channels, keeps its own copy of
// the ballot store, runs the elimination rounds on every election end and
// compares each result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module irv_tally_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [irv_pkg::CfgW-1:0] cfg_wdata,
	input  logic                     s_axis_tvalid,
	input  logic                     s_axis_tready,
	input  logic [7:0]               s_axis_tdata,
	input  logic                     s_axis_tuser,
	input  logic                     s_axis_tlast,
	input  logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	input  logic [23:0]              m_axis_tdata,
	output int                       fail_count,
	output int                       outcomes_pending
);
	import irv_pkg::*;

	typedef struct packed {
		logic [4:0]  winner;
		logic [12:0] stored;
		logic        overflow;
	} outcome_t;

	logic [BallotW-1:0] ballots [MaxBallots];
	logic [4:0]         ranks_held [MaxBallots];
	int unsigned        ballot_fill;
	logic [BallotW-1:0] open_ballot;
	int unsigned        open_ranks;
	logic               dropped;
	logic [CfgW-1:0]    cand_reg;
	outcome_t           outcomes [$];

	function automatic int unsigned standing();
		if (cand_reg == 0)
			return 1;
		if (cand_reg > MaxCandidates)
			return MaxCandidates;
		return cand_reg;
	endfunction

	function automatic void shelve_ballot();
		if (ballot_fill < MaxBallots) begin
			ballots[ballot_fill] = open_ballot;
			ranks_held[ballot_fill] = 5'(open_ranks);
			ballot_fill++;
		end else begin
			dropped = 1'b1;
		end
		open_ballot = '0;
		open_ranks = 0;
	endfunction

	// run rounds until one candidate is left; lowest tally goes, ties to lowest number
	function automatic logic [4:0] runoff_winner();
		int unsigned c;
		int unsigned left;
		int unsigned votes [MaxCandidates];
		logic [MaxCandidates-1:0] out_mask;
		int unsigned low;
		int unsigned lowest;
		bit found;
		int unsigned cand;
		int unsigned len;
		c = standing();
		left = c;
		out_mask = '0;
		while (left > 1) begin
			foreach (votes[k])
				votes[k] = 0;
			for (int unsigned b = 0; b < ballot_fill; b++) begin
				len = ranks_held[b];
				if (len > MaxCandidates)
					len = MaxCandidates;
				for (int unsigned r = 0; r < len; r++) begin
					cand = ballots[b][4*r +: 4];
					if (cand < c && !out_mask[cand]) begin
						votes[cand]++;
						break;
					end
				end
			end
			found = 0;
			low = 0;
			lowest = 0;
			for (int unsigned k = 0; k < c; k++) begin
				if (!out_mask[k] && (!found || votes[k] < lowest)) begin
					found = 1;
					lowest = votes[k];
					low = k;
				end
			end
			out_mask[low] = 1'b1;
			left--;
		end
		for (int unsigned k = 0; k < c; k++)
			if (!out_mask[k])
				return 5'(k + 1);
		return 5'd1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [4:0] pref;
		outcome_t   exp_o;
		outcome_t   got_o;
		if (!arst_n) begin
			ballot_fill = 0;
			open_ballot = '0;
			open_ranks = 0;
			dropped = 1'b0;
			cand_reg = 5'd16;
			outcomes.delete();
			fail_count = 0;
			outcomes_pending = 0;
		end else begin
			// result side: compare against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got_o.winner = m_axis_tdata[4:0];
				got_o.stored = m_axis_tdata[17:5];
				got_o.overflow = m_axis_tdata[18];
				if (outcomes.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: winner %0d stored %0d overflow %0d",
							got_o.winner, got_o.stored, got_o.overflow);
				end else begin
					exp_o = outcomes.pop_front();
					if (got_o != exp_o) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp winner %0d stored %0d ovf %0d, got %0d %0d %0d",
								exp_o.winner, exp_o.stored, exp_o.overflow,
								got_o.winner, got_o.stored, got_o.overflow);
					end
				end
			end
			// request side: build ballots, tally on election end
			if (s_axis_tvalid && s_axis_tready) begin
				pref = s_axis_tdata[4:0];
				if (pref >= 1 && pref <= standing() && open_ranks < MaxCandidates) begin
					open_ballot[4*open_ranks +: 4] = 4'(pref - 5'd1);
					open_ranks++;
				end
				if (s_axis_tuser || (s_axis_tlast && open_ranks > 0))
					shelve_ballot();
				if (s_axis_tlast) begin
					exp_o.winner = runoff_winner();
					exp_o.stored = ballot_fill[12:0];
					exp_o.overflow = dropped;
					outcomes = {outcomes, exp_o};
					ballot_fill = 0;
					dropped = 1'b0;
					open_ballot = '0;
					open_ranks = 0;
				end
			end
			if (cfg_we)
				cand_reg = cfg_wdata;
			outcomes_pending = outcomes.size();
		end
	end

endmodule

[tb/sv/tb_instant_runoff_tally.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_instant_runoff_tally: stimulus and verdict for the runoff tally
// Drives directed and random elections under several candidate counts with
// random gaps on both sides, long receiver hold-offs and one election
// that overflows the ballot store; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_instant_runoff_tally;
	import irv_pkg::*;

	localparam int IdleLimit = 200000;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [CfgW-1:0] cfg_wdata;
	logic            s_axis_tvalid;
	logic            s_axis_tready;
	logic [7:0]      s_axis_tdata;   // [4:0] preference
	logic            s_axis_tuser;   // ballot_end
	logic            s_axis_tlast;   // election_end
	logic            m_axis_tvalid;
	logic            m_axis_tready;
	logic [23:0]     m_axis_tdata;   // [4:0] winner, [17:5] ballots_stored, [18] overflow
	int              fail_count;
	int              outcomes_pending;
	int              cycle_no;
	int              idle_cycles;
	int              requests_sent;
	int              cur_c;          // effective candidate count for stimulus
	bit              send_steady;    // no gaps for the current election

	instant_runoff_tally dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	irv_tally_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.s_axis_tvalid    (s_axis_tvalid),
		.s_axis_tready    (s_axis_tready),
		.s_axis_tdata     (s_axis_tdata),
		.s_axis_tuser     (s_axis_tuser),
		.s_axis_tlast     (s_axis_tlast),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.m_axis_tdata     (m_axis_tdata),
		.fail_count       (fail_count),
		.outcomes_pending (outcomes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls in stretches, and two long hold-offs that start while the
	// block is counting, so the result waits and requests keep coming against a full block
	initial begin
		int stall_pct;
		int long_holds;
		m_axis_tready = 1'b0;
		stall_pct = 0;
		long_holds = 0;
		@(posedge arst_n);
		forever begin
			if (!s_axis_tready && !m_axis_tvalid &&
				(long_holds == 0 || (long_holds == 1 && cycle_no >= 20000))) begin
				m_axis_tready <= 1'b0;
				long_holds++;
				repeat (500) @(posedge clk);
			end else begin
				if ($urandom_range(0, 63) == 0)
					stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
				if ($urandom_range(0, 99) < stall_pct && $urandom_range(0, 9) == 0) begin
					m_axis_tready <= 1'b0;
					repeat (pick_gap() + 1) @(posedge clk);
				end else begin
					m_axis_tready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	// offer one request and hold it until the block takes it
	task automatic send_request(input logic [4:0] pref, input logic bend, input logic eend);
		int gap;
		gap = send_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, pref};
		s_axis_tuser <= bend;
		s_axis_tlast <= eend;
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
		requests_sent++;
	endtask

	// drain every outstanding result, let the block settle, then write the register
	task automatic set_candidates(input logic [CfgW-1:0] value);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outcomes_pending != 0 || m_axis_tvalid)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_c = (value == 0) ? 1 : (value > MaxCandidates) ? MaxCandidates : value;
	endtask

	// one election of random ballots; noisy ones carry out-of-range or repeated ranks
	task automatic run_election(input int nballots, input int noise_pct);
		int perm [MaxCandidates];
		int len;
		int j;
		int t;
		int close_style;
		bit noisy;
		logic [4:0] pref;
		close_style = $urandom_range(0, 2);
		send_steady = ($urandom_range(0, 3) == 0);
		for (int b = 0; b < nballots; b++) begin
			noisy = ($urandom_range(0, 99) < noise_pct);
			for (int i = 0; i < MaxCandidates; i++)
				perm[i] = i;
			for (int i = cur_c - 1; i > 0; i--) begin
				j = $urandom_range(0, i);
				t = perm[i];
				perm[i] = perm[j];
				perm[j] = t;
			end
			case ($urandom_range(0, 19))
				0: begin
					len = 0;
				end
				1: begin
					len = $urandom_range(17, 20);
				end
				default: begin
					len = $urandom_range(1, cur_c);
				end
			endcase
			if (len == 0) begin
				send_request(5'd0, 1'b1, b == nballots - 1 && close_style == 0);
			end else begin
				for (int r = 0; r < len; r++) begin
					pref = noisy ? 5'($urandom_range(0, 31)) : 5'(perm[r % cur_c] + 1);
					send_request(pref, r == len - 1,
						b == nballots - 1 && r == len - 1 && close_style == 0);
				end
			end
		end
		// close without a ballot end: a partial ballot, or nothing left open
		if (close_style == 1 || nballots == 0)
			send_request(5'($urandom_range(1, cur_c)), 1'b0, 1'b1);
		else if (close_style == 2)
			send_request(5'd0, 1'b0, 1'b1);
		send_steady = 1'b0;
	endtask

	initial begin
		logic [CfgW-1:0] sweep [6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		cycle_no = 0;
		idle_cycles = 0;
		requests_sent = 0;
		cur_c = MaxCandidates;
		send_steady = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all sixteen at reset value; extremes and ignored preferences
		send_request(5'd16, 1'b0, 1'b0);
		send_request(5'd1, 1'b0, 1'b0);
		send_request(5'd0, 1'b0, 1'b0);
		send_request(5'd17, 1'b0, 1'b0);
		send_request(5'd31, 1'b1, 1'b0);
		send_request(5'd0, 1'b1, 1'b0);      // empty ballot
		for (int r = 0; r < 18; r++)         // overfull ballot
			send_request(5'((r % 16) + 1), r == 17, 1'b0);
		send_request(5'd7, 1'b0, 1'b1);      // partial ballot closed by election end
		send_request(5'd0, 1'b0, 1'b1);      // election with no ballots at all

		// directed: store overflow with two candidates
		set_candidates(5'd2);
		send_steady = 1'b1;
		for (int b = 0; b <= MaxBallots; b++)
			send_request(5'((b % 3 == 0) ? 1 : 2), 1'b1, b == MaxBallots);
		send_steady = 1'b0;
		requests_sent = 0;

		// sweep the register through its extremes and typical values
		sweep[0] = 5'd1;
		sweep[1] = 5'd0;
		sweep[2] = 5'd31;
		sweep[3] = 5'd17;
		sweep[4] = 5'd16;
		sweep[5] = 5'd3;
		foreach (sweep[i]) begin
			set_candidates(sweep[i]);
			run_election($urandom_range(1, 12), 20);
			run_election($urandom_range(0, 6), 10);
		end

		// random elections, mostly well formed, register changed now and then
		while (requests_sent < 1200) begin
			if ($urandom_range(0, 3) == 0)
				set_candidates(5'($urandom_range(0, 31)));
			run_election(($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 20), ($urandom_range(0, 4) == 0) ? 60 : 5);
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outcomes_pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
